// ===== rtl/core/ffua_pkg.sv =====
// Shared types and constants of the first-fit unit allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffua_pkg;

  // Request codes carried by the opcode field
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Reset value of the active unit count register
  localparam logic [10:0] ACTIVE_RESET = 11'd1024;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FREE,
    ST_DONE
  } ffua_state_t;

  // One result item
  typedef struct packed {
    logic        success;
    logic [9:0]  start_index;
    logic [10:0] freed_count;
  } ffua_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/first_fit_unit_allocator.sv =====
// Top level of the first-fit unit allocator: configuration, output register, core.
//
// Requests enter on the in_ channel (in_valid / in_stall). An allocate request
// (opcode 0) stamps owner_id on the lowest run of alloc_size free units among
// the first active_units units and returns its start; a free request (opcode 1)
// clears every unit of owner_id and returns how many were cleared. One result
// item per request leaves on the out_ channel (out_valid / out_stall).
// Requests are handled one at a time. An allocate scans and then writes the
// owner map one entry a cycle; a rejected one goes straight to its result. A
// free walks the whole map. The result sits in an output register; the next
// request is taken while it waits, and the core holds a finished result until
// the register frees up, so a stalled receiver backs up to in_stall.
// After reset the owner map is swept to zero while in_stall stays high;
// cfg_ valid / ready writes active_units at any time and active_units
// resets to 1024.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_unit_allocator #(
  parameter int UNITS   = 1024,
  parameter int ID_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [10:0] in_alloc_size,
  input  wire logic [15:0] in_owner_id,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_success,
  output logic [9:0]       out_start_index,
  output logic [10:0]      out_freed_count,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_active_units
);

  import ffua_pkg::*;

  localparam int AW = $clog2(UNITS);

  logic [10:0]        active_r;
  logic               out_valid_r;
  ffua_res_t          out_r;
  logic               req_ready;
  logic               res_valid;
  logic               res_ready;
  ffua_res_t          res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [ID_BITS-1:0] mem_rdata;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_r <= cfg_active_units;
    end
  end

  // Output register: load when empty or when the held item leaves
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_r.success;
  assign out_start_index = out_r.start_index;
  assign out_freed_count = out_r.freed_count;
  assign in_stall        = !req_ready;

  ffua_ctrl #(
    .UNITS   (UNITS),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_valid),
    .req_ready      (req_ready),
    .req_opcode     (in_opcode),
    .req_alloc_size (in_alloc_size),
    .req_owner_id   (in_owner_id),
    .active_units   (active_r),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  ffua_mem #(
    .DEPTH (UNITS),
    .WIDTH (ID_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ffua_mem.sv =====
// Owner map storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ffua_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, data valid in the following cycle
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/ffua_ctrl.sv =====
// Request sequencer: clearing pass, first-fit scan, run stamping and owner release.
`timescale 1ns / 1ps
`default_nettype none

module ffua_ctrl #(
  parameter int UNITS   = 1024,
  parameter int ID_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request side
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire logic                     req_opcode,
  input  wire logic [10:0]              req_alloc_size,
  input  wire logic [15:0]              req_owner_id,
  input  wire logic [10:0]              active_units,
  // owner map
  output logic                          mem_we,
  output logic [$clog2(UNITS)-1:0]      mem_waddr,
  output logic [ID_BITS-1:0]            mem_wdata,
  output logic [$clog2(UNITS)-1:0]      mem_raddr,
  input  wire logic [ID_BITS-1:0]       mem_rdata,
  // result side
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output ffua_pkg::ffua_res_t           res
);

  import ffua_pkg::*;

  localparam int AW = $clog2(UNITS);
  localparam int CW = $clog2(UNITS + 1);
  localparam logic [AW-1:0] LAST_UNIT = AW'(UNITS - 1);

  ffua_state_t         state_r, state_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic                issue_r, issue_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]       run_r, run_nxt;
  logic [AW-1:0]       start_r, start_nxt;
  logic [CW-1:0]       size_r, size_nxt;
  logic [AW-1:0]       last_r, last_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  ffua_res_t           res_r, res_nxt;

  logic [31:0]         id_ext;
  logic [ID_BITS-1:0]  req_id;
  logic [31:0]         size32;
  logic [31:0]         limit32;
  logic                alloc_bad;
  logic [AW-1:0]       run_start;
  logic [31:0]         start32;
  logic [31:0]         count32;

  // Decode the request fields
  assign id_ext    = {16'b0, req_owner_id};
  assign req_id    = id_ext[ID_BITS-1:0];
  assign size32    = {21'b0, req_alloc_size};
  assign limit32   = ({21'b0, active_units} > 32'(UNITS)) ? 32'(UNITS)
                                                          : {21'b0, active_units};
  assign alloc_bad = (req_id == '0) || (size32 == 32'd0) || (size32 > limit32);
  assign run_start = (run_r == '0) ? pend_idx_r : start_r;
  assign start32   = 32'(start_r);
  assign count32   = 32'(count_r);

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= '0;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    run_r      <= run_nxt;
    start_r    <= start_nxt;
    size_r     <= size_nxt;
    last_r     <= last_nxt;
    id_r       <= id_nxt;
    count_r    <= count_nxt;
    res_r      <= res_nxt;
  end

  // Next state, memory access and result
  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    issue_nxt    = issue_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = ptr_r;
    run_nxt      = run_r;
    start_nxt    = start_r;
    size_nxt     = size_r;
    last_nxt     = last_r;
    id_nxt       = id_r;
    count_nxt    = count_r;
    res_nxt      = res_r;
    req_ready    = 1'b0;
    res_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = ptr_r;
    mem_wdata    = '0;
    mem_raddr    = ptr_r;

    unique case (state_r)
      ST_CLEAR: begin
        // sweep zeros through the map after reset
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_UNIT) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          id_nxt    = req_id;
          ptr_nxt   = '0;
          run_nxt   = '0;
          count_nxt = '0;
          res_nxt   = '{success: 1'b0, start_index: '0, freed_count: '0};
          if (req_opcode == OP_ALLOC) begin
            size_nxt = CW'(size32);
            last_nxt = AW'(limit32 - 32'd1);
            if (alloc_bad) begin
              state_nxt = ST_DONE;
            end else begin
              issue_nxt = 1'b1;
              state_nxt = ST_SCAN;
            end
          end else begin
            last_nxt        = LAST_UNIT;
            res_nxt.success = 1'b1;
            if (req_id == '0) begin
              state_nxt = ST_DONE;
            end else begin
              issue_nxt = 1'b1;
              state_nxt = ST_FREE;
            end
          end
        end
      end

      ST_SCAN: begin
        // issue the next read
        if (issue_r) begin
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + 1'b1;
          if (ptr_r == last_r) begin
            issue_nxt = 1'b0;
          end
        end
        // track the free run on returned data
        if (pend_r) begin
          if (mem_rdata == '0) begin
            start_nxt = run_start;
            run_nxt   = run_r + 1'b1;
            if (run_r + 1'b1 == size_r) begin
              issue_nxt = 1'b0;
              pend_nxt  = 1'b0;
              ptr_nxt   = run_start;
              count_nxt = size_r;
              state_nxt = ST_WRITE;
            end else if (pend_idx_r == last_r) begin
              issue_nxt = 1'b0;
              state_nxt = ST_DONE;
            end
          end else begin
            run_nxt = '0;
            if (pend_idx_r == last_r) begin
              issue_nxt = 1'b0;
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_WRITE: begin
        // stamp the owner on the run
        mem_we    = 1'b1;
        mem_wdata = id_r;
        ptr_nxt   = ptr_r + 1'b1;
        count_nxt = count_r - 1'b1;
        if (count_r == CW'(1)) begin
          res_nxt   = '{success: 1'b1, start_index: start32[9:0], freed_count: '0};
          state_nxt = ST_DONE;
        end
      end

      ST_FREE: begin
        // issue the next read
        if (issue_r) begin
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + 1'b1;
          if (ptr_r == last_r) begin
            issue_nxt = 1'b0;
          end
        end
        // release entries of the owner on returned data
        if (pend_r) begin
          mem_waddr = pend_idx_r;
          if (mem_rdata == id_r) begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (pend_idx_r == last_r) begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        // hand the result to the output register
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Free results carry the count gathered during the pass
  always_comb begin
    res = res_r;
    if (res_r.success && res_r.start_index == '0 && res_r.freed_count == '0) begin
      res.freed_count = count32[10:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffua_checker.sv =====
// Port-level checks of the first-fit unit allocator and their binding.
`timescale 1ns / 1ps
`default_nettype none

module ffua_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_success,
  input wire logic [9:0]  out_start_index,
  input wire logic [10:0] out_freed_count
);

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // Reset starts the clearing pass, so no item may enter
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken during clearing pass");

  // A stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_success)
      && $stable(out_start_index) && $stable(out_freed_count))
    else $error("stalled result item changed");

  // A failed allocation carries no start and no count
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_start_index == 10'd0 && out_freed_count == 11'd0)
    else $error("failed item carries data");

  // A release is always a success with no start
  a_free_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_freed_count != 11'd0 |-> out_success && out_start_index == 10'd0)
    else $error("release item malformed");

endmodule

bind first_fit_unit_allocator ffua_checker u_ffua_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_success     (out_success),
  .out_start_index (out_start_index),
  .out_freed_count (out_freed_count)
);

`default_nettype wire
